### hdl/gdbm_pkg.sv
// gdbm_pkg: shared types, constants and constant tables of the gaussian dither unit
// used by gdbm_ctrl, gdbm_datapath and gaussian_dither_box_muller_unit
// no dependencies
package gdbm_pkg;

    // word formats
    localparam int SAMPLE_BITS   = 16;
    localparam int OUT_FRAC_BITS = 8;
    localparam int OUT_BITS      = SAMPLE_BITS + OUT_FRAC_BITS;
    localparam int ACC_BITS      = OUT_BITS + 3;
    localparam int RND_SHIFT     = 44 - OUT_FRAC_BITS;

    // configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DITHER_WEIGHT = 1'b0,
        REG_SEED_VALUE    = 1'b1
    } cfg_reg_t;

    localparam logic [15:0] WEIGHT_RESET = 16'd4096;
    localparam logic [31:0] SEED_RESET   = 32'd0;
    localparam logic [15:0] SEED_LOW     = 16'h330E;

    // generator and math constants
    localparam logic [31:0] LCG_MUL_LO = 32'hDEECE66D;
    localparam logic [2:0]  LCG_MUL_HI = 3'd5;
    localparam logic [47:0] LCG_ADD    = 48'hB;
    localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    // shared multiplier
    localparam int MUL_A_BITS = 38;
    localparam int MUL_B_BITS = 32;
    localparam int MUL_P_BITS = 64;

    // loop lengths
    localparam int SQ_STEPS   = 16;
    localparam int SQRT_STEPS = 20;
    localparam int CNT_BITS   = 5;
    localparam logic [2:0] COS_LAST_TERM = 3'd4;
    localparam logic [2:0] SIN_LAST_TERM = 3'd3;

    // reciprocals floor(2^32 / d) of the series divisors
    localparam logic [31:0] RCP_90 = 32'((64'd1 << 32) / 64'd90);
    localparam logic [31:0] RCP_56 = 32'((64'd1 << 32) / 64'd56);
    localparam logic [31:0] RCP_30 = 32'((64'd1 << 32) / 64'd30);
    localparam logic [31:0] RCP_12 = 32'((64'd1 << 32) / 64'd12);
    localparam logic [31:0] RCP_2  = 32'((64'd1 << 32) / 64'd2);
    localparam logic [31:0] RCP_72 = 32'((64'd1 << 32) / 64'd72);
    localparam logic [31:0] RCP_42 = 32'((64'd1 << 32) / 64'd42);
    localparam logic [31:0] RCP_20 = 32'((64'd1 << 32) / 64'd20);
    localparam logic [31:0] RCP_6  = 32'((64'd1 << 32) / 64'd6);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_of_block;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sample_out;
        logic                       clipped;
    } out_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LCG_MUL,
        OP_LCG_S1,
        OP_LCG_S2,
        OP_NORM,
        OP_SQ_MUL,
        OP_SQ_UPD,
        OP_LN_MUL,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_ANG_MUL,
        OP_X2_MUL,
        OP_X2_DIV,
        OP_DIV_FIX,
        OP_HRN_MUL,
        OP_DIV_MUL,
        OP_SIN_MUL,
        OP_TRIG_END,
        OP_RC_MUL,
        OP_RCW_MUL,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LCG1_MUL,
        S_LCG1_ADD,
        S_LCG2_MUL,
        S_LCG2_ADD,
        S_NORM,
        S_SQ_MUL,
        S_SQ_UPD,
        S_LN_MUL,
        S_SQRT_INIT,
        S_SQRT,
        S_ANG_MUL,
        S_X2_MUL,
        S_X2_DIV,
        S_DIV_FIX,
        S_HRN_MUL,
        S_DIV_MUL,
        S_SIN_MUL,
        S_TRIG_END,
        S_RC_MUL,
        S_RCW_MUL,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] term;
    } dp_cmd_t;

    typedef struct packed {
        logic weight_zero;
        logic norm_done;
        logic is_sin;
    } dp_status_t;

    // divisor of one series term
    function automatic logic [6:0] div_const(input logic is_sin, input logic [2:0] term);
        logic [6:0] d;
        d = 7'd2;
        if (is_sin) begin
            unique case (term)
                3'd0:    d = 7'd72;
                3'd1:    d = 7'd42;
                3'd2:    d = 7'd20;
                default: d = 7'd6;
            endcase
        end else begin
            unique case (term)
                3'd0:    d = 7'd90;
                3'd1:    d = 7'd56;
                3'd2:    d = 7'd30;
                3'd3:    d = 7'd12;
                default: d = 7'd2;
            endcase
        end
        return d;
    endfunction

    // reciprocal of one series term divisor
    function automatic logic [31:0] div_recip(input logic is_sin, input logic [2:0] term);
        logic [31:0] r;
        r = RCP_2;
        if (is_sin) begin
            unique case (term)
                3'd0:    r = RCP_72;
                3'd1:    r = RCP_42;
                3'd2:    r = RCP_20;
                default: r = RCP_6;
            endcase
        end else begin
            unique case (term)
                3'd0:    r = RCP_90;
                3'd1:    r = RCP_56;
                3'd2:    r = RCP_30;
                3'd3:    r = RCP_12;
                default: r = RCP_2;
            endcase
        end
        return r;
    endfunction

endpackage

### hdl/gdbm_ctrl.sv
// gdbm_ctrl: sequencer of the gaussian dither unit, one datapath command a cycle except
// while idle with no input or stalled on a waiting result; depends on gdbm_pkg
module gdbm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  gdbm_pkg::dp_status_t status,
    output gdbm_pkg::dp_cmd_t    cmd
);

    gdbm_pkg::ctrl_state_t state_reg, state_next;
    logic [gdbm_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [2:0] term_reg, term_next;
    logic m_valid_reg, m_valid_next;
    logic [2:0] last_term;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gdbm_pkg::S_IDLE;
            cnt_reg     <= '0;
            term_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            term_reg    <= term_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign last_term = status.is_sin ? gdbm_pkg::SIN_LAST_TERM : gdbm_pkg::COS_LAST_TERM;
    assign m_valid   = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        term_next    = term_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.op       = gdbm_pkg::OP_NONE;
        cmd.term     = term_reg;
        unique case (state_reg)
            gdbm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = gdbm_pkg::OP_LOAD;
                    state_next = status.weight_zero ? gdbm_pkg::S_FINISH : gdbm_pkg::S_LCG1_MUL;
                end
            end
            gdbm_pkg::S_LCG1_MUL: begin
                cmd.op     = gdbm_pkg::OP_LCG_MUL;
                state_next = gdbm_pkg::S_LCG1_ADD;
            end
            gdbm_pkg::S_LCG1_ADD: begin
                cmd.op     = gdbm_pkg::OP_LCG_S1;
                state_next = gdbm_pkg::S_LCG2_MUL;
            end
            gdbm_pkg::S_LCG2_MUL: begin
                cmd.op     = gdbm_pkg::OP_LCG_MUL;
                state_next = gdbm_pkg::S_LCG2_ADD;
            end
            gdbm_pkg::S_LCG2_ADD: begin
                cmd.op     = gdbm_pkg::OP_LCG_S2;
                state_next = gdbm_pkg::S_NORM;
            end
            gdbm_pkg::S_NORM: begin
                cmd.op = gdbm_pkg::OP_NORM;
                if (status.norm_done) begin
                    cnt_next   = '0;
                    state_next = gdbm_pkg::S_SQ_MUL;
                end
            end
            gdbm_pkg::S_SQ_MUL: begin
                cmd.op     = gdbm_pkg::OP_SQ_MUL;
                state_next = gdbm_pkg::S_SQ_UPD;
            end
            gdbm_pkg::S_SQ_UPD: begin
                cmd.op = gdbm_pkg::OP_SQ_UPD;
                if (cnt_reg == gdbm_pkg::CNT_BITS'(gdbm_pkg::SQ_STEPS - 1)) begin
                    state_next = gdbm_pkg::S_LN_MUL;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = gdbm_pkg::S_SQ_MUL;
                end
            end
            gdbm_pkg::S_LN_MUL: begin
                cmd.op     = gdbm_pkg::OP_LN_MUL;
                state_next = gdbm_pkg::S_SQRT_INIT;
            end
            gdbm_pkg::S_SQRT_INIT: begin
                cmd.op     = gdbm_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = gdbm_pkg::S_SQRT;
            end
            gdbm_pkg::S_SQRT: begin
                cmd.op = gdbm_pkg::OP_SQRT_STEP;
                if (cnt_reg == gdbm_pkg::CNT_BITS'(gdbm_pkg::SQRT_STEPS - 1)) begin
                    state_next = gdbm_pkg::S_ANG_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            gdbm_pkg::S_ANG_MUL: begin
                cmd.op     = gdbm_pkg::OP_ANG_MUL;
                term_next  = '0;
                state_next = gdbm_pkg::S_X2_MUL;
            end
            gdbm_pkg::S_X2_MUL: begin
                cmd.op     = gdbm_pkg::OP_X2_MUL;
                state_next = gdbm_pkg::S_X2_DIV;
            end
            gdbm_pkg::S_X2_DIV: begin
                cmd.op     = gdbm_pkg::OP_X2_DIV;
                state_next = gdbm_pkg::S_DIV_FIX;
            end
            gdbm_pkg::S_DIV_FIX: begin
                cmd.op = gdbm_pkg::OP_DIV_FIX;
                if (term_reg == last_term) begin
                    state_next = status.is_sin ? gdbm_pkg::S_SIN_MUL : gdbm_pkg::S_TRIG_END;
                end else begin
                    term_next  = term_reg + 1'b1;
                    state_next = gdbm_pkg::S_HRN_MUL;
                end
            end
            gdbm_pkg::S_HRN_MUL: begin
                cmd.op     = gdbm_pkg::OP_HRN_MUL;
                state_next = gdbm_pkg::S_DIV_MUL;
            end
            gdbm_pkg::S_DIV_MUL: begin
                cmd.op     = gdbm_pkg::OP_DIV_MUL;
                state_next = gdbm_pkg::S_DIV_FIX;
            end
            gdbm_pkg::S_SIN_MUL: begin
                cmd.op     = gdbm_pkg::OP_SIN_MUL;
                state_next = gdbm_pkg::S_TRIG_END;
            end
            gdbm_pkg::S_TRIG_END: begin
                cmd.op     = gdbm_pkg::OP_TRIG_END;
                state_next = gdbm_pkg::S_RC_MUL;
            end
            gdbm_pkg::S_RC_MUL: begin
                cmd.op     = gdbm_pkg::OP_RC_MUL;
                state_next = gdbm_pkg::S_RCW_MUL;
            end
            gdbm_pkg::S_RCW_MUL: begin
                cmd.op     = gdbm_pkg::OP_RCW_MUL;
                state_next = gdbm_pkg::S_FINISH;
            end
            gdbm_pkg::S_FINISH: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = gdbm_pkg::OP_FINISH;
                    m_valid_next = 1'b1;
                    state_next   = gdbm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gdbm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hdl/gdbm_datapath.sv
// gdbm_datapath: generator, config registers, shared multiplier, log/root/series steps
// and the output register of the gaussian dither unit; depends on gdbm_pkg
module gdbm_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gdbm_pkg::dp_cmd_t                    cmd,
    output gdbm_pkg::dp_status_t                 status,
    input  logic                                 cfg_valid,
    input  logic [gdbm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [gdbm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  gdbm_pkg::in_word_t                   s_data,
    output gdbm_pkg::out_word_t                  m_data
);

    localparam int ACC_BITS = gdbm_pkg::ACC_BITS;
    localparam int OUT_BITS = gdbm_pkg::OUT_BITS;
    localparam logic signed [ACC_BITS-1:0] OUT_MAX =
        ACC_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] OUT_MIN =
        ACC_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));
    localparam logic [52:0] RND_HALF = 53'd1 << (gdbm_pkg::RND_SHIFT - 1);

    // control registers
    logic [15:0] weight_reg, weight_next;
    logic [31:0] seed_reg, seed_next;
    logic [47:0] gen_reg, gen_next;

    // working registers
    logic signed [gdbm_pkg::SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic        last_reg, last_next;
    logic [gdbm_pkg::MUL_P_BITS-1:0] mul_reg, mul_next;
    logic [48:0] norm_reg, norm_next;
    logic [5:0]  shift_reg, shift_next;
    logic [31:0] x_reg, x_next;
    logic [15:0] frac_reg, frac_next;
    logic [39:0] rem_reg, rem_next;
    logic [39:0] root_reg, root_next;
    logic [39:0] bit_reg, bit_next;
    logic [31:0] phase_reg, phase_next;
    logic [29:0] ang_reg, ang_next;
    logic [29:0] x2_reg, x2_next;
    logic [29:0] n_reg, n_next;
    logic [30:0] t_reg, t_next;
    logic [16:0] c_reg, c_next;
    logic        cneg_reg, cneg_next;
    gdbm_pkg::out_word_t out_reg, out_next;

    // combinational helpers
    logic [gdbm_pkg::MUL_A_BITS-1:0] mul_a;
    logic [gdbm_pkg::MUL_B_BITS-1:0] mul_b;
    logic [gdbm_pkg::MUL_A_BITS+gdbm_pkg::MUL_B_BITS-1:0] mul_full;
    logic        mul_en;
    logic [15:0] lcg_cross;
    logic [47:0] gen_step;
    logic [31:0] ph_rot, ph_f, ph_mag;
    logic [1:0]  quad;
    logic        fneg;
    logic [21:0] ln_t;
    logic [32:0] sq_hi;
    logic [6:0]  div_d;
    logic [31:0] div_r;
    logic [31:0] q0;
    logic [39:0] q_rem;
    logic [30:0] q_fix;
    logic [39:0] sq_trial;
    logic [30:0] trig_v;
    logic [16:0] c_val;
    logic        c_neg;
    logic [52:0] nz_u;
    logic signed [ACC_BITS-1:0] acc_base, acc_sum;

    assign status.weight_zero = (weight_reg == 16'd0);
    assign status.norm_done   = norm_reg[48];
    assign status.is_sin      = quad[0];
    assign m_data             = out_reg;

    // generator step: low word product comes from the multiplier, the rest is narrow
    assign lcg_cross = 16'(gen_reg[15:0] * gdbm_pkg::LCG_MUL_HI)
                     + 16'(gen_reg[47:32] * gdbm_pkg::LCG_MUL_LO[15:0]);
    assign gen_step  = mul_reg[47:0] + {lcg_cross, 32'd0} + gdbm_pkg::LCG_ADD;

    // phase reduction to a quadrant and a signed offset
    assign ph_rot = phase_reg + 32'h2000_0000;
    assign quad   = ph_rot[31:30];
    assign ph_f   = phase_reg - {quad, 30'd0};
    assign fneg   = ph_f[31];
    assign ph_mag = fneg ? (32'd0 - ph_f) : ph_f;

    // log argument and squaring step
    assign ln_t  = {shift_reg, 16'd0} - {6'd0, frac_reg};
    assign sq_hi = mul_reg[63:31];

    // constant divide with one correction step
    assign div_d = gdbm_pkg::div_const(quad[0], cmd.term);
    assign div_r = gdbm_pkg::div_recip(quad[0], cmd.term);
    assign q0    = mul_reg[63:32];
    assign q_rem = {10'd0, n_reg} - (40'(q0) * 40'(div_d));
    assign q_fix = 31'(q0) + ((q_rem >= 40'(div_d)) ? 31'd1 : 31'd0);

    // root step
    assign sq_trial = root_reg + bit_reg;

    // series result to q.16 with sign
    assign trig_v = quad[0] ? mul_reg[60:30] : t_reg;
    assign c_val  = trig_v[30:14];
    always_comb begin
        unique case (quad)
            2'd0:    c_neg = 1'b0;
            2'd1:    c_neg = !fneg;
            2'd2:    c_neg = 1'b1;
            default: c_neg = fneg;
        endcase
    end

    // rounding and sum
    assign nz_u     = (mul_reg[52:0] + RND_HALF) >> gdbm_pkg::RND_SHIFT;
    assign acc_base = ACC_BITS'(sample_reg) <<< gdbm_pkg::OUT_FRAC_BITS;
    always_comb begin
        if (weight_reg == 16'd0) begin
            acc_sum = acc_base;
        end else if (cneg_reg) begin
            acc_sum = acc_base - signed'(ACC_BITS'(nz_u));
        end else begin
            acc_sum = acc_base + signed'(ACC_BITS'(nz_u));
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            gdbm_pkg::OP_LCG_MUL: begin
                mul_a = 38'(gen_reg[31:0]);
                mul_b = gdbm_pkg::LCG_MUL_LO;
            end
            gdbm_pkg::OP_SQ_MUL: begin
                mul_a = 38'(x_reg);
                mul_b = x_reg;
            end
            gdbm_pkg::OP_LN_MUL: begin
                mul_a = 38'(ln_t);
                mul_b = gdbm_pkg::LN2_Q32;
            end
            gdbm_pkg::OP_ANG_MUL: begin
                mul_a = 38'(ph_mag[29:0]);
                mul_b = gdbm_pkg::PI_Q30;
            end
            gdbm_pkg::OP_X2_MUL: begin
                mul_a = 38'(mul_reg[60:31]);
                mul_b = 32'(mul_reg[60:31]);
            end
            gdbm_pkg::OP_X2_DIV, gdbm_pkg::OP_DIV_MUL: begin
                mul_a = 38'(mul_reg[59:30]);
                mul_b = div_r;
            end
            gdbm_pkg::OP_HRN_MUL: begin
                mul_a = 38'(x2_reg);
                mul_b = 32'(t_reg);
            end
            gdbm_pkg::OP_SIN_MUL: begin
                mul_a = 38'(ang_reg);
                mul_b = 32'(t_reg);
            end
            gdbm_pkg::OP_RC_MUL: begin
                mul_a = 38'(root_reg[19:0]);
                mul_b = 32'(c_reg);
            end
            gdbm_pkg::OP_RCW_MUL: begin
                mul_a = mul_reg[37:0];
                mul_b = 32'(weight_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // next values
    always_comb begin
        weight_next = weight_reg;
        seed_next   = seed_reg;
        gen_next    = gen_reg;
        sample_next = sample_reg;
        last_next   = last_reg;
        mul_next    = mul_en ? mul_full[gdbm_pkg::MUL_P_BITS-1:0] : mul_reg;
        norm_next   = norm_reg;
        shift_next  = shift_reg;
        x_next      = x_reg;
        frac_next   = frac_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        phase_next  = phase_reg;
        ang_next    = ang_reg;
        x2_next     = x2_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        c_next      = c_reg;
        cneg_next   = cneg_reg;
        out_next    = out_reg;

        // register writes
        if (cfg_valid) begin
            if (cfg_index == gdbm_pkg::REG_DITHER_WEIGHT) begin
                weight_next = cfg_data[15:0];
            end else if (cfg_index == gdbm_pkg::REG_SEED_VALUE) begin
                seed_next = cfg_data[31:0];
            end
        end

        unique case (cmd.op)
            gdbm_pkg::OP_LOAD: begin
                sample_next = s_data.sample_in;
                last_next   = s_data.last_of_block;
            end
            gdbm_pkg::OP_LCG_S1: begin
                gen_next   = gen_step;
                norm_next  = 49'h1_0000_0000_0000 - {1'b0, gen_step};
                shift_next = '0;
            end
            gdbm_pkg::OP_LCG_S2: begin
                gen_next   = gen_step;
                phase_next = gen_step[47:16];
            end
            gdbm_pkg::OP_NORM: begin
                if (norm_reg[48]) begin
                    x_next    = norm_reg[48:17];
                    frac_next = '0;
                end else if (norm_reg[48:41] == 8'd0) begin
                    norm_next  = norm_reg << 8;
                    shift_next = shift_reg + 6'd8;
                end else begin
                    norm_next  = norm_reg << 1;
                    shift_next = shift_reg + 6'd1;
                end
            end
            gdbm_pkg::OP_SQ_UPD: begin
                if (sq_hi[32]) begin
                    x_next    = sq_hi[32:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end else begin
                    x_next    = sq_hi[31:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
            end
            gdbm_pkg::OP_SQRT_INIT: begin
                rem_next  = {1'b0, mul_reg[53:31], 16'd0};
                root_next = '0;
                bit_next  = 40'd1 << 38;
            end
            gdbm_pkg::OP_SQRT_STEP: begin
                if (rem_reg >= sq_trial) begin
                    rem_next  = rem_reg - sq_trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            gdbm_pkg::OP_X2_MUL: begin
                ang_next = mul_reg[60:31];
            end
            gdbm_pkg::OP_X2_DIV: begin
                x2_next = mul_reg[59:30];
                n_next  = mul_reg[59:30];
            end
            gdbm_pkg::OP_DIV_MUL: begin
                n_next = mul_reg[59:30];
            end
            gdbm_pkg::OP_DIV_FIX: begin
                t_next = gdbm_pkg::ONE_Q30 - q_fix;
            end
            gdbm_pkg::OP_TRIG_END: begin
                c_next    = c_val;
                cneg_next = c_neg && (c_val != 17'd0);
            end
            gdbm_pkg::OP_FINISH: begin
                // saturate to the output range
                if (acc_sum > OUT_MAX) begin
                    out_next.sample_out = OUT_MAX[OUT_BITS-1:0];
                    out_next.clipped    = 1'b1;
                end else if (acc_sum < OUT_MIN) begin
                    out_next.sample_out = OUT_MIN[OUT_BITS-1:0];
                    out_next.clipped    = 1'b1;
                end else begin
                    out_next.sample_out = acc_sum[OUT_BITS-1:0];
                    out_next.clipped    = 1'b0;
                end
                // block end reloads the generator
                if (last_reg) begin
                    gen_next = {seed_reg, gdbm_pkg::SEED_LOW};
                end
            end
            default: begin
            end
        endcase
    end

    // registers with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= gdbm_pkg::WEIGHT_RESET;
            seed_reg   <= gdbm_pkg::SEED_RESET;
            gen_reg    <= {gdbm_pkg::SEED_RESET, gdbm_pkg::SEED_LOW};
        end else begin
            weight_reg <= weight_next;
            seed_reg   <= seed_next;
            gen_reg    <= gen_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
        mul_reg    <= mul_next;
        norm_reg   <= norm_next;
        shift_reg  <= shift_next;
        x_reg      <= x_next;
        frac_reg   <= frac_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        phase_reg  <= phase_next;
        ang_reg    <= ang_next;
        x2_reg     <= x2_next;
        n_reg      <= n_next;
        t_reg      <= t_next;
        c_reg      <= c_next;
        cneg_reg   <= cneg_next;
        out_reg    <= out_next;
    end

endmodule

### hdl/gaussian_dither_box_muller_unit.sv
// with dithering on, a word passes through the generator steps, normalizing, 16 squaring passes,
// a bit-serial root and the series terms on one shared multiplier before its result is
// registered; with zero weight the word goes straight to the finish
// one word is in flight at a time; the next is taken once the result is registered and shown
// on the output; a waiting result holds off the next finish
// synchronous active-low reset clears control, weight to 1.0, seed to 0, generator to 0x330E
module gaussian_dither_box_muller_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gdbm_pkg::in_word_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gdbm_pkg::out_word_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gdbm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gdbm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    gdbm_pkg::dp_cmd_t    cmd;
    gdbm_pkg::dp_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    gdbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gdbm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data)
    );

    // a loaded word makes the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is in progress");

    // datapath loads only on an accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == gdbm_pkg::OP_LOAD) |-> (s_valid && s_ready))
        else $error("load without an accepted word");

    // finishing always presents a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == gdbm_pkg::OP_FINISH) |=> m_valid)
        else $error("finished word not presented");

    // clipped results sit at a range end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
            ((m_data.sample_out == {1'b0, {(gdbm_pkg::OUT_BITS-1){1'b1}}}) ||
             (m_data.sample_out == {1'b1, {(gdbm_pkg::OUT_BITS-1){1'b0}}})))
        else $error("clipped flag without saturated value");

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench of the gaussian dither unit, with its own drand48 and
// fixed-point box-muller predictor, random handshake gaps and register changes between phases
// depends on gdbm_pkg and gaussian_dither_box_muller_unit
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        gdbm_pkg::in_word_t word;
        int                 gap;
    } pending_word_t;

    localparam longint unsigned MASK48   = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned LCG_MULT = 64'h5_DEEC_E66D;
    localparam longint unsigned ONE30    = 64'd1 << 30;
    localparam int              DRAIN    = 120;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    gdbm_pkg::in_word_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    gdbm_pkg::out_word_t  m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [gdbm_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [gdbm_pkg::CFG_DATA_BITS-1:0] cfg_data;

    // predictor copy of registers and generator
    logic [15:0]      weight_reg;
    logic [31:0]      seed_reg;
    longint unsigned  lcg_state;

    pending_word_t        send_queue[$];
    gdbm_pkg::out_word_t  expected_words[$];
    pending_word_t  cur_word;
    logic           have_cur;
    int             gap_cnt;
    int             stall_cnt;
    int             fail_count;
    int             sent_count;
    int             got_count;
    int             clip_count;
    logic           no_idle;

    gaussian_dither_box_muller_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned lcg_advance();
        lcg_state = (lcg_state * LCG_MULT + 64'hB) & MASK48;
        return lcg_state;
    endfunction

    // -2 ln(m / 2^48) in Q.16
    function automatic longint unsigned neg_two_ln(longint unsigned m);
        int p;
        longint unsigned x, frac, t;
        p = 48;
        frac = 0;
        while (p > 0 && m[p] == 1'b0) p--;
        x = (p >= 31) ? (m >> (p - 31)) : (m << (31 - p));
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32)) begin
                frac = frac | 64'd1;
                x = x >> 1;
            end
        end
        t = longint'(48 - p) * 64'd65536 - frac;
        return (t * 64'hB172_17F8) >> 31;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cos_series(longint unsigned x);
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t = ONE30 - x2 / 90;
        t = ONE30 - ((x2 * t) >> 30) / 56;
        t = ONE30 - ((x2 * t) >> 30) / 30;
        t = ONE30 - ((x2 * t) >> 30) / 12;
        t = ONE30 - ((x2 * t) >> 30) / 2;
        return t;
    endfunction

    function automatic longint unsigned sin_series(longint unsigned x);
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t = ONE30 - x2 / 72;
        t = ONE30 - ((x2 * t) >> 30) / 42;
        t = ONE30 - ((x2 * t) >> 30) / 20;
        t = ONE30 - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    // cosine of a phase in turns, magnitude in Q.16 and sign apart
    function automatic longint unsigned cos_of_phase(logic [31:0] phase, output logic neg);
        logic [31:0] shifted, fu;
        logic [1:0]  quad;
        logic        fneg;
        longint unsigned mag, x, v;
        shifted = phase + 32'h2000_0000;
        quad = shifted[31:30];
        fu = phase - {quad, 30'd0};
        fneg = fu[31];
        mag = fneg ? (64'h1_0000_0000 - longint'(fu)) : longint'(fu);
        x = (mag * 64'd3373259426) >> 31;
        if (quad == 2'd0) begin
            v = cos_series(x);
            neg = 1'b0;
        end else if (quad == 2'd2) begin
            v = cos_series(x);
            neg = 1'b1;
        end else if (quad == 2'd1) begin
            v = sin_series(x);
            neg = ~fneg;
        end else begin
            v = sin_series(x);
            neg = fneg;
        end
        v = v >> 14;
        if (v == 0) neg = 1'b0;
        return v;
    endfunction

    function automatic gdbm_pkg::out_word_t dither_predict(gdbm_pkg::in_word_t w);
        gdbm_pkg::out_word_t res;
        longint acc, hi;
        longint unsigned s1, s2, r, c, prod, nz;
        logic cneg;
        acc = longint'(w.sample_in) * 256;
        if (weight_reg != 16'd0) begin
            s1 = lcg_advance();
            s2 = lcg_advance();
            r = int_sqrt(neg_two_ln((64'd1 << 48) - s1) << 16);
            c = cos_of_phase(s2[47:16], cneg);
            prod = r * c * longint'(weight_reg);
            nz = (prod + (64'd1 << (gdbm_pkg::RND_SHIFT - 1))) >> gdbm_pkg::RND_SHIFT;
            acc = cneg ? acc - longint'(nz) : acc + longint'(nz);
        end
        hi = (longint'(1) << (gdbm_pkg::OUT_BITS - 1)) - 1;
        res.clipped = 1'b0;
        if (acc > hi) begin
            acc = hi;
            res.clipped = 1'b1;
        end else if (acc < -hi - 1) begin
            acc = -hi - 1;
            res.clipped = 1'b1;
        end
        res.sample_out = acc[gdbm_pkg::OUT_BITS-1:0];
        if (w.last_of_block)
            lcg_state = {seed_reg, gdbm_pkg::SEED_LOW};
        return res;
    endfunction

    // ---------------- input driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            have_cur <= 1'b0;
            gap_cnt  <= 0;
        end else if (s_valid && s_ready) begin
            expected_words.push_back(dither_predict(s_data));
            sent_count++;
            if (send_queue.size() > 0 && send_queue[0].gap == 0) begin
                cur_word = send_queue.pop_front();
                s_data  <= cur_word.word;
                s_valid <= 1'b1;
            end else begin
                s_valid  <= 1'b0;
                have_cur <= 1'b0;
            end
        end else if (!s_valid) begin
            if (have_cur) begin
                if (gap_cnt == 0) begin
                    s_data  <= cur_word.word;
                    s_valid <= 1'b1;
                end else begin
                    gap_cnt <= gap_cnt - 1;
                end
            end else if (send_queue.size() > 0) begin
                cur_word = send_queue.pop_front();
                have_cur <= 1'b1;
                gap_cnt  <= cur_word.gap;
            end
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge aclk) begin
        gdbm_pkg::out_word_t exp_word;
        int nxt;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            nxt = stall_cnt;
            if (m_valid && m_ready) begin
                got_count++;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", m_data);
                    fail_count++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (m_data.clipped) clip_count++;
                    if (m_data.sample_out !== exp_word.sample_out) begin
                        $error("sample_out expected %0d actual %0d",
                               exp_word.sample_out, m_data.sample_out);
                        fail_count++;
                    end
                    if (m_data.clipped !== exp_word.clipped) begin
                        $error("clipped expected %0b actual %0b",
                               exp_word.clipped, m_data.clipped);
                        fail_count++;
                    end
                end
                nxt = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (nxt == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready   <= 1'b0;
                nxt = nxt - 1;
            end
            stall_cnt <= nxt;
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_word(input logic signed [15:0] smp, input logic last);
        pending_word_t p;
        p.word.sample_in     = smp;
        p.word.last_of_block = last;
        p.gap = no_idle ? 0 : $urandom_range(0, 18);
        send_queue.push_back(p);
    endtask

    task automatic wait_idle();
        while (send_queue.size() > 0 || have_cur || s_valid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // one register write, with cfg_valid low again before the next one
    task automatic write_reg(input gdbm_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == gdbm_pkg::REG_DITHER_WEIGHT) weight_reg = value[15:0];
        else seed_reg = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [15:0] weights[8];
        logic [31:0] seeds[8];
        logic signed [15:0] smp;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        weight_reg = gdbm_pkg::WEIGHT_RESET;
        seed_reg   = gdbm_pkg::SEED_RESET;
        lcg_state  = {gdbm_pkg::SEED_RESET, gdbm_pkg::SEED_LOW};
        fail_count = 0;
        sent_count = 0;
        got_count  = 0;
        clip_count = 0;
        no_idle    = 1'b0;
        @(posedge aclk);
        wait (aresetn);
        @(posedge aclk);

        // defaults after reset: extremes, block end reseeds from seed zero
        add_word(16'sd0, 1'b0);
        add_word(16'sd32767, 1'b0);
        add_word(-16'sd32768, 1'b0);
        add_word(16'sd1, 1'b0);
        add_word(-16'sd1, 1'b1);
        add_word(16'sd100, 1'b0);
        wait_idle();

        // zero weight passes through, block end still reloads
        write_reg(gdbm_pkg::REG_DITHER_WEIGHT, 32'd0);
        add_word(16'sd32767, 1'b0);
        add_word(-16'sd32768, 1'b0);
        add_word(16'sh5555, 1'b1);
        wait_idle();

        // full weight near the rails to force saturation both ways;
        // seed change takes effect only after the next block end
        write_reg(gdbm_pkg::REG_DITHER_WEIGHT, 32'hFFFF);
        write_reg(gdbm_pkg::REG_SEED_VALUE, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) begin
            add_word(16'sd32767, 1'b0);
            add_word(-16'sd32768, i == 3);
        end
        wait_idle();

        // random phases
        weights = '{16'hFFFF, 16'd0, 16'd1, 16'd4096, 16'h8000, 16'd0, 16'd0, 16'd0};
        seeds   = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        for (int ph = 5; ph < 8; ph++) begin
            weights[ph] = 16'($urandom_range(1, 16'hFFFF));
            seeds[ph]   = $urandom;
        end
        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph % 3 == 2);
            write_reg(gdbm_pkg::REG_DITHER_WEIGHT, {16'd0, weights[ph]});
            write_reg(gdbm_pkg::REG_SEED_VALUE, seeds[ph]);
            for (int i = 0; i < 66; i++) begin
                if ($urandom_range(0, 7) == 0)
                    smp = $urandom_range(0, 1)
                        ? 16'(32767 - int'($urandom_range(0, 40)))
                        : 16'(-32768 + int'($urandom_range(0, 40)));
                else
                    smp = 16'($urandom);
                add_word(smp, $urandom_range(0, 15) == 0);
            end
            wait_idle();
        end

        $display("sent %0d words, checked %0d results (%0d saturated) over 11 register settings",
                 sent_count, got_count, clip_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
